// ----- sv/slfr_pkg.sv -----
// ----------------------------------------------------------------------------
// slfr_pkg
// Types and constants shared by the STX/length/check-byte frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

  localparam int BUFFER_BYTES_DEF = 2048;
  localparam int POS_W            = 12;
  localparam int INDEX_W          = 11;
  localparam int LEN_W            = 16;
  localparam int CNT_W            = 12;

  localparam logic [7:0]       START_BYTE = 8'h02;
  localparam logic [POS_W-1:0] LEN_HI_POS = 12'd5;
  localparam logic [POS_W-1:0] LEN_LO_POS = 12'd6;

  // req_type codes on the input channel
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_PARITY  = 2'd1;
  localparam logic [1:0] REQ_CONFIRM = 2'd2;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_PARITY,
    CMD_CONFIRM,
    CMD_IDLE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_HUNT       = 3'd0,
    PH_RECV       = 3'd1,
    PH_WAIT_CHECK = 3'd2,
    PH_DONE       = 3'd3,
    PH_PARITY     = 3'd4,
    PH_CHECK_ERR  = 3'd5,
    PH_OVERFLOW   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_PARITY    = 3'd2,
    ST_CHECK_ERR = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef struct packed {
    logic               byte_store;
    logic [INDEX_W-1:0] byte_index;
    logic [7:0]         byte_value;
    logic               frame_ready;
    logic               report_valid;
    status_t            report_status;
    logic [POS_W-1:0]   report_length;
  } result_t;

endpackage

// ----- sv/slfr_in_if.sv -----
// ----------------------------------------------------------------------------
// slfr_in_if
// Request channel: one received byte, parity event or confirm per request.
// ----------------------------------------------------------------------------
interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ----- sv/slfr_out_if.sv -----
// ----------------------------------------------------------------------------
// slfr_out_if
// Result channel: stored byte, frame-ready flag and frame report.
// ----------------------------------------------------------------------------
interface slfr_out_if;
  logic        valid;
  logic        ready;
  logic        byte_store;
  logic [10:0] byte_index;
  logic [7:0]  byte_value;
  logic        frame_ready;
  logic        report_valid;
  logic [2:0]  report_status;
  logic [11:0] report_length;

  modport source (
    output valid, output byte_store, output byte_index, output byte_value,
    output frame_ready, output report_valid, output report_status,
    output report_length, input ready
  );
  modport sink (
    input valid, input byte_store, input byte_index, input byte_value,
    input frame_ready, input report_valid, input report_status,
    input report_length, output ready
  );
endinterface

// ----- sv/stx_length_sum_frame_receiver.sv -----
// Path: an accepted request is written into the queue; when the engine takes
//   it, its result is registered in the result register and shown from then on.
// Throughput: one request per clock cycle while the result side is ready,
//   set by the engine's phase update; a two-entry queue absorbs result stalls.
// Reset (rst, synchronous): phase back to hunting, counters and sum cleared,
//   queue and result register emptied.
// ----------------------------------------------------------------------------
// stx_length_sum_frame_receiver
// Command-frame receiver for STX / big-endian length / check-byte framing.
// The front decodes each request (byte, parity event, confirm) into a
// command and queues it; the back walks the receive phases, keeps the
// running 8-bit sum and emits one result per request.
// ----------------------------------------------------------------------------
module stx_length_sum_frame_receiver #(
  parameter int BUFFER_BYTES = slfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  slfr_in_if.sink    in_req,
  slfr_out_if.source out_rsp
);

  // queue head between the decoder and the frame engine
  logic           q_valid;
  logic           q_ready;
  slfr_pkg::cmd_t q_cmd;

  // Decode and buffer requests; hold them when the engine stalls.
  slfr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (in_req),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready)
  );

  // Advance the frame phase and register one result per command.
  // Overflow fires on the data byte at store position BUFFER_BYTES-1.
  slfr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready),
    .rsp     (out_rsp)
  );

endmodule

// ----- sv/slfr_front.sv -----
// ----------------------------------------------------------------------------
// slfr_front
// Accept requests, decode them into commands and hold them in a
// two-entry queue for the frame engine.
// ----------------------------------------------------------------------------
module slfr_front (
  input  logic          clk,
  input  logic          rst,
  slfr_in_if.sink       req,
  output logic          q_valid,
  output slfr_pkg::cmd_t q_cmd,
  input  logic          q_ready
);

  slfr_pkg::cmd_t slot0;
  slfr_pkg::cmd_t slot1;
  logic [1:0]     count;
  logic [1:0]     count_next;
  logic [1:0]     count_after_pop;
  slfr_pkg::cmd_t new_cmd;
  logic           push;
  logic           pop;

  always_comb begin
    new_cmd.data = req.rx_byte;
    case (req.req_type)
      slfr_pkg::REQ_BYTE:    new_cmd.kind = slfr_pkg::CMD_BYTE;
      slfr_pkg::REQ_PARITY:  new_cmd.kind = slfr_pkg::CMD_PARITY;
      slfr_pkg::REQ_CONFIRM: new_cmd.kind = slfr_pkg::CMD_CONFIRM;
      default:               new_cmd.kind = slfr_pkg::CMD_IDLE;
    endcase
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = slot0;
  assign pop       = q_valid && q_ready;

  assign count_after_pop = count - {1'b0, pop};
  assign count_next      = count_after_pop + {1'b0, push};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Head always sits in slot0: place the new entry there when the queue
  // is empty after the pop, else advance slot1 into it on pop.
  always_ff @(posedge clk) begin
    if (push && count_after_pop == 2'd0) begin
      slot0 <= new_cmd;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && count_after_pop != 2'd0) begin
      slot1 <= new_cmd;
    end
  end

endmodule

// ----- sv/slfr_back.sv -----
// ----------------------------------------------------------------------------
// slfr_back
// Frame engine: run the receive phases on each command and register
// one result per command.
// ----------------------------------------------------------------------------
module slfr_back #(
  parameter int BUFFER_BYTES = slfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  slfr_pkg::cmd_t q_cmd,
  output logic           q_ready,
  slfr_out_if.source     rsp
);

  localparam logic [slfr_pkg::POS_W-1:0] LAST_POS = slfr_pkg::POS_W'(BUFFER_BYTES - 1);

  slfr_pkg::phase_t               phase;
  slfr_pkg::phase_t               phase_next;
  logic [slfr_pkg::POS_W-1:0]     write_position;
  logic [slfr_pkg::POS_W-1:0]     write_position_next;
  logic [slfr_pkg::LEN_W-1:0]     declared_length;
  logic [slfr_pkg::LEN_W-1:0]     declared_length_next;
  logic [slfr_pkg::CNT_W-1:0]     payload_count;
  logic [slfr_pkg::CNT_W-1:0]     payload_count_next;
  logic [7:0]                     running_sum;
  logic [7:0]                     running_sum_next;
  logic [slfr_pkg::POS_W-1:0]     pos_inc;
  logic [slfr_pkg::CNT_W-1:0]     count_inc;
  logic [slfr_pkg::LEN_W-1:0]     full_length;
  slfr_pkg::result_t              res;
  slfr_pkg::result_t              res_q;
  logic                           out_valid;
  logic                           take;

  assign q_ready = !out_valid || rsp.ready;
  assign take    = q_valid && q_ready;

  assign pos_inc     = write_position + slfr_pkg::POS_W'(1);
  assign count_inc   = payload_count + slfr_pkg::CNT_W'(1);
  assign full_length = {declared_length[15:8], q_cmd.data};

  always_comb begin
    phase_next           = phase;
    write_position_next  = write_position;
    declared_length_next = declared_length;
    payload_count_next   = payload_count;
    running_sum_next     = running_sum;
    res                  = '0;
    res.report_status    = slfr_pkg::ST_OK;

    case (q_cmd.kind)
      slfr_pkg::CMD_BYTE: begin
        case (phase)
          slfr_pkg::PH_RECV: begin
            running_sum_next    = running_sum + q_cmd.data;
            res.byte_store      = 1'b1;
            res.byte_index      = write_position[slfr_pkg::INDEX_W-1:0];
            res.byte_value      = q_cmd.data;
            write_position_next = pos_inc;
            if (write_position == slfr_pkg::LEN_HI_POS) begin
              declared_length_next = {q_cmd.data, 8'h00};
            end else if (write_position == slfr_pkg::LEN_LO_POS) begin
              declared_length_next = full_length;
              payload_count_next   = '0;
              if (full_length == '0) begin
                phase_next = slfr_pkg::PH_WAIT_CHECK;
              end
            end else if (write_position > slfr_pkg::LEN_LO_POS) begin
              payload_count_next = count_inc;
              if (write_position >= LAST_POS) begin
                phase_next = slfr_pkg::PH_OVERFLOW;
              end else if ({4'b0, count_inc} == declared_length) begin
                phase_next = slfr_pkg::PH_WAIT_CHECK;
              end
            end
          end
          slfr_pkg::PH_WAIT_CHECK: begin
            res.byte_store      = 1'b1;
            res.byte_index      = write_position[slfr_pkg::INDEX_W-1:0];
            res.byte_value      = q_cmd.data;
            write_position_next = pos_inc;
            if (q_cmd.data == 8'(-running_sum)) begin
              phase_next = slfr_pkg::PH_DONE;
            end else begin
              phase_next = slfr_pkg::PH_CHECK_ERR;
            end
          end
          slfr_pkg::PH_DONE, slfr_pkg::PH_PARITY,
          slfr_pkg::PH_CHECK_ERR, slfr_pkg::PH_OVERFLOW: begin
            // drop bytes until the frame is confirmed
          end
          default: begin
            // hunting: every byte lands at position 0
            res.byte_store      = 1'b1;
            res.byte_value      = q_cmd.data;
            write_position_next = 12'd1;
            if (q_cmd.data == slfr_pkg::START_BYTE) begin
              running_sum_next = 8'h00;
              phase_next       = slfr_pkg::PH_RECV;
            end else begin
              phase_next = slfr_pkg::PH_HUNT;
            end
          end
        endcase
      end
      slfr_pkg::CMD_PARITY: begin
        if (phase == slfr_pkg::PH_HUNT || phase == slfr_pkg::PH_RECV ||
            phase == slfr_pkg::PH_WAIT_CHECK) begin
          phase_next = slfr_pkg::PH_PARITY;
        end
      end
      slfr_pkg::CMD_CONFIRM: begin
        res.report_valid  = 1'b1;
        res.report_length = write_position;
        case (phase)
          slfr_pkg::PH_RECV, slfr_pkg::PH_WAIT_CHECK:
                                   res.report_status = slfr_pkg::ST_SHORT;
          slfr_pkg::PH_DONE:       res.report_status = slfr_pkg::ST_OK;
          slfr_pkg::PH_PARITY:     res.report_status = slfr_pkg::ST_PARITY;
          slfr_pkg::PH_CHECK_ERR:  res.report_status = slfr_pkg::ST_CHECK_ERR;
          slfr_pkg::PH_OVERFLOW:   res.report_status = slfr_pkg::ST_OVERFLOW;
          default: begin
            res.report_valid  = 1'b0;
            res.report_length = '0;
          end
        endcase
        phase_next = slfr_pkg::PH_HUNT;
      end
      default: begin
        // unused request code: report frame_ready only
      end
    endcase

    res.frame_ready = (phase_next == slfr_pkg::PH_DONE) ||
                      (phase_next == slfr_pkg::PH_CHECK_ERR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= slfr_pkg::PH_HUNT;
      write_position  <= '0;
      declared_length <= '0;
      payload_count   <= '0;
      running_sum     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        phase           <= phase_next;
        write_position  <= write_position_next;
        declared_length <= declared_length_next;
        payload_count   <= payload_count_next;
        running_sum     <= running_sum_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.byte_store    = res_q.byte_store;
  assign rsp.byte_index    = res_q.byte_index;
  assign rsp.byte_value    = res_q.byte_value;
  assign rsp.frame_ready   = res_q.frame_ready;
  assign rsp.report_valid  = res_q.report_valid;
  assign rsp.report_status = res_q.report_status;
  assign rsp.report_length = res_q.report_length;

endmodule

// ----- verif/stx_length_sum_frame_receiver_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stx_length_sum_frame_receiver_tb
// Self-checking bench for the STX / length / check-byte frame receiver. A
// scoreboard class predicts one result per accepted request from its own
// copy of the receive phase, store position, length field and running sum.
// Traffic is a short directed opening and then random frames (clean, short,
// parity-hit, bad check, trailing bytes) mixed with loose requests. Both
// channels idle in random bursts, and the result side holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module stx_length_sum_frame_receiver_tb;

  localparam int STORE_BYTES = slfr_pkg::BUFFER_BYTES_DEF;
  // Data bytes sent at most per frame: enough to run past the last store slot.
  localparam int MAX_DATA_SENT = STORE_BYTES - 3;
  localparam int RANDOM_ITEMS = 780;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;

  // Ways a generated frame departs from a clean one.
  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_CHECK,
    FLAW_SHORT,
    FLAW_PARITY,
    FLAW_EXTRA
  } flaw_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the receiver state, queues one expected result per
  // accepted request and checks results against the oldest entry.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    slfr_pkg::phase_t  phase;
    logic [11:0]       fill_pos;
    logic [15:0]       length_field;
    logic [15:0]       data_seen;
    logic [7:0]        byte_sum;
    slfr_pkg::result_t pending_results[$];
    int unsigned       mismatches;

    function new();
      phase        = slfr_pkg::PH_HUNT;
      fill_pos     = '0;
      length_field = '0;
      data_seen    = '0;
      byte_sum     = '0;
      mismatches   = 0;
    endfunction

    task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
      mismatches++;
      if (mismatches <= 100) begin
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got_v, want_v);
      end
    endtask

    function void note_request(logic [1:0] kind, logic [7:0] data);
      slfr_pkg::result_t r;
      r = '0;
      case (kind)
        slfr_pkg::REQ_BYTE: begin
          case (phase)
            slfr_pkg::PH_RECV: begin
              byte_sum     = byte_sum + data;
              r.byte_store = 1'b1;
              r.byte_index = fill_pos[10:0];
              r.byte_value = data;
              if (fill_pos == slfr_pkg::LEN_HI_POS) begin
                length_field = {data, 8'h00};
              end else if (fill_pos == slfr_pkg::LEN_LO_POS) begin
                length_field = length_field | {8'h00, data};
                data_seen    = '0;
                if (length_field == 16'd0) phase = slfr_pkg::PH_WAIT_CHECK;
              end else if (fill_pos > slfr_pkg::LEN_LO_POS) begin
                data_seen = data_seen + 16'd1;
                // last store slot overflows even when it was the last data byte
                if (int'(fill_pos) + 1 >= STORE_BYTES) phase = slfr_pkg::PH_OVERFLOW;
                else if (data_seen == length_field) phase = slfr_pkg::PH_WAIT_CHECK;
              end
              fill_pos = fill_pos + 12'd1;
            end
            slfr_pkg::PH_WAIT_CHECK: begin
              r.byte_store = 1'b1;
              r.byte_index = fill_pos[10:0];
              r.byte_value = data;
              fill_pos     = fill_pos + 12'd1;
              phase        = (data == 8'(-byte_sum)) ? slfr_pkg::PH_DONE
                                                     : slfr_pkg::PH_CHECK_ERR;
            end
            slfr_pkg::PH_DONE, slfr_pkg::PH_PARITY,
            slfr_pkg::PH_CHECK_ERR, slfr_pkg::PH_OVERFLOW: ;
            default: begin
              // hunting: every byte lands at slot 0, only STX opens a frame
              r.byte_store = 1'b1;
              r.byte_index = '0;
              r.byte_value = data;
              fill_pos     = 12'd1;
              if (data == slfr_pkg::START_BYTE) begin
                byte_sum = '0;
                phase    = slfr_pkg::PH_RECV;
              end else begin
                phase = slfr_pkg::PH_HUNT;
              end
            end
          endcase
        end
        slfr_pkg::REQ_PARITY: begin
          if (phase inside {slfr_pkg::PH_HUNT, slfr_pkg::PH_RECV,
                            slfr_pkg::PH_WAIT_CHECK}) phase = slfr_pkg::PH_PARITY;
        end
        slfr_pkg::REQ_CONFIRM: begin
          r.report_valid = 1'b1;
          case (phase)
            slfr_pkg::PH_RECV, slfr_pkg::PH_WAIT_CHECK:
                                    r.report_status = slfr_pkg::ST_SHORT;
            slfr_pkg::PH_DONE:      r.report_status = slfr_pkg::ST_OK;
            slfr_pkg::PH_PARITY:    r.report_status = slfr_pkg::ST_PARITY;
            slfr_pkg::PH_CHECK_ERR: r.report_status = slfr_pkg::ST_CHECK_ERR;
            slfr_pkg::PH_OVERFLOW:  r.report_status = slfr_pkg::ST_OVERFLOW;
            default:                r.report_valid  = 1'b0;
          endcase
          if (r.report_valid) r.report_length = fill_pos;
          phase = slfr_pkg::PH_HUNT;
        end
        default: ;
      endcase
      r.frame_ready = (phase == slfr_pkg::PH_DONE) || (phase == slfr_pkg::PH_CHECK_ERR);
      pending_results.push_back(r);
    endfunction

    task check_result(slfr_pkg::result_t got);
      slfr_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.byte_store != want.byte_store)
          report_mismatch("byte_store", got.byte_store, want.byte_store);
        if (got.byte_index != want.byte_index)
          report_mismatch("byte_index", got.byte_index, want.byte_index);
        if (got.byte_value != want.byte_value)
          report_mismatch("byte_value", got.byte_value, want.byte_value);
        if (got.frame_ready != want.frame_ready)
          report_mismatch("frame_ready", got.frame_ready, want.frame_ready);
        if (got.report_valid != want.report_valid)
          report_mismatch("report_valid", got.report_valid, want.report_valid);
        if (got.report_status != want.report_status)
          report_mismatch("report_status", got.report_status, want.report_status);
        if (got.report_length != want.report_length)
          report_mismatch("report_length", got.report_length, want.report_length);
      end
    endtask
  endclass

  logic clk;
  logic rst;

  slfr_in_if  in_req();
  slfr_out_if out_rsp();

  stx_length_sum_frame_receiver u_top (
    .clk     (clk),
    .rst     (rst),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  frame_scoreboard sb = new();

  // Run-wide traffic controls, written by the stimulus process.
  logic        quiet;     // no idling on either side in the closing stretch
  logic        hold_req;  // ask the result side for one long hold-off
  int unsigned requests_sent;

  // --------------------------------------------------------------------------
  // Clock.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if the traffic never drains.
  // --------------------------------------------------------------------------
  initial begin
    #12_000_000;
    $display("stx_length_sum_frame_receiver_tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver. Optionally idle for a burst, then present the request at
  // a falling edge and hold it until a rising edge sees ready. Valid stays
  // high afterwards so back-to-back requests need no extra assignment.
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [1:0] kind, input logic [7:0] data);
    int unsigned gap;
    if (!quiet && !hold_req && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_req.valid    <= 1'b0;
      in_req.req_type <= 2'($urandom_range(0, 2));
      in_req.rx_byte  <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_req.valid    <= 1'b1;
    in_req.req_type <= kind;
    in_req.rx_byte  <= data;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(kind, data);
    requests_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Frame generator: STX, four free header bytes, big-endian length, data,
  // check byte, then a confirm. Overlong frames are cut a little past the
  // last store slot since the receiver ignores everything after overflow.
  // --------------------------------------------------------------------------
  task automatic drive_frame(input int unsigned len, input flaw_t flaw);
    int unsigned body;
    int unsigned cut;
    int unsigned i;
    logic [7:0]  b;
    logic [7:0]  csum;
    body = 7 + ((len > MAX_DATA_SENT) ? MAX_DATA_SENT : len);
    cut  = $urandom_range(0, body - 1);
    csum = '0;
    send_req(slfr_pkg::REQ_BYTE, slfr_pkg::START_BYTE);
    for (i = 0; i < body; i++) begin
      // short frame: confirm arrives before the frame is through
      if (i == cut && flaw == FLAW_SHORT) break;
      // parity hit mid-frame; the rest of the frame is then dropped
      if (i == cut && flaw == FLAW_PARITY) send_req(slfr_pkg::REQ_PARITY, 8'($urandom));
      if (i == 4) begin
        b = len[15:8];
      end else if (i == 5) begin
        b = len[7:0];
      end else if (i == body - 1) begin
        b = -csum;
        if (flaw == FLAW_BAD_CHECK) b = b + 8'($urandom_range(1, 255));
      end else begin
        b = 8'($urandom);
      end
      csum = csum + b;
      send_req(slfr_pkg::REQ_BYTE, b);
    end
    if (flaw == FLAW_EXTRA) begin
      // bytes and a parity event after the check byte must be dropped
      repeat ($urandom_range(1, 3)) send_req(slfr_pkg::REQ_BYTE, 8'($urandom));
      send_req(slfr_pkg::REQ_PARITY, 8'($urandom));
    end
    send_req(slfr_pkg::REQ_CONFIRM, 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready bursts, plus one long hold-off on request
  // while the sender keeps pushing, so the internal queue fills and the
  // request channel backs up.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    logic        held;
    held          = 1'b0;
    out_rsp.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17);
        out_rsp.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: sample every accepted result at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    slfr_pkg::result_t got;
    if (!rst && out_rsp.valid && out_rsp.ready) begin
      got.byte_store    = out_rsp.byte_store;
      got.byte_index    = out_rsp.byte_index;
      got.byte_value    = out_rsp.byte_value;
      got.frame_ready   = out_rsp.frame_ready;
      got.report_valid  = out_rsp.report_valid;
      got.report_status = slfr_pkg::status_t'(out_rsp.report_status);
      got.report_length = out_rsp.report_length;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned random_base;
    int unsigned len;
    int unsigned pick;
    logic        hold_done;
    flaw_t       flaw;

    rst             = 1'b1;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    requests_sent   = 0;
    in_req.valid    = 1'b0;
    in_req.req_type = slfr_pkg::REQ_BYTE;
    in_req.rx_byte  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening.
    send_req(slfr_pkg::REQ_CONFIRM, 8'h00);   // confirm while hunting: no report
    send_req(slfr_pkg::REQ_BYTE, 8'h00);      // loose bytes land at slot 0
    send_req(slfr_pkg::REQ_BYTE, 8'hFF);
    send_req(slfr_pkg::REQ_PARITY, 8'hFF);    // parity while hunting forces error
    send_req(slfr_pkg::REQ_BYTE, slfr_pkg::START_BYTE); // dropped in the parity phase
    send_req(slfr_pkg::REQ_PARITY, 8'h00);    // second parity event dropped
    send_req(slfr_pkg::REQ_CONFIRM, 8'hA5);   // reports leftover store position
    send_req(slfr_pkg::REQ_CONFIRM, 8'h5A);   // back in hunting: no report
    drive_frame(0, FLAW_EXTRA);               // zero length, then trailing junk
    drive_frame(1, FLAW_BAD_CHECK);

    // Random part: mostly well-formed frames with random content and flaws,
    // the rest loose requests of any kind.
    random_base = requests_sent;
    while (requests_sent < random_base + RANDOM_ITEMS) begin
      if (!hold_done && requests_sent >= random_base + 150) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        drive_frame(20, FLAW_NONE);
        hold_req  = 1'b0;
      end
      if (requests_sent >= random_base + 600) quiet = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
                                            : $urandom_range(0, 24);
        pick = $urandom_range(0, 7);
        flaw = (pick < 4) ? FLAW_NONE : flaw_t'(pick - 3);
        drive_frame(len, flaw);
      end else begin
        send_req(2'($urandom_range(0, 2)),
                 ($urandom_range(0, 3) == 0) ? slfr_pkg::START_BYTE : 8'($urandom));
      end
    end

    // Drain: drop valid, wait for every pending result, then let the
    // pipeline settle before judging.
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("stx_length_sum_frame_receiver_tb passed");
    end else begin
      $display("stx_length_sum_frame_receiver_tb failed");
    end
    $finish;
  end

endmodule
